[rtl/core/bsl_pkg.sv]
// Shared types and constants of the breakpoint search and interpolation block.
package bsl_pkg;

    localparam int KEY_W  = 20;
    localparam int TIME_W = 48;
    localparam int CNT_W  = 9;
    localparam int IDX_W  = 8;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic CFG_PREFILL = 1'b0;
    localparam logic CFG_DECODE  = 1'b1;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_BELOW  = 2'd1;
    localparam logic [1:0] ST_EXTRAP = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic              is_query;
        logic              sel;
        logic              wr_ok;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] tval;
        logic [KEY_W-1:0]  count;
        logic [CNT_W-1:0]  entries;
    } item_t;

endpackage

[rtl/core/bsl_ram.sv]
// Generic single-port RAM with registered read data.
module bsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/bsl_queue.sv]
// Two-beat queue between the front and back parts.
module bsl_queue
    import bsl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (fill_reg == 2'd0);
    assign full  = (fill_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/bsl_front.sv]
// Front part: configuration registers, command acceptance and classification.
module bsl_front
    import bsl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  logic              table_select,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [KEY_W-1:0]  entry_key,
    input  logic [TIME_W-1:0] entry_time,
    input  logic [KEY_W-1:0]  query_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              queue_full,
    output logic              push,
    output item_t             push_item
);

    logic [CNT_W-1:0] prefill_reg;
    logic [CNT_W-1:0] prefill_next;
    logic [CNT_W-1:0] decode_reg;
    logic [CNT_W-1:0] decode_next;
    logic [CNT_W-1:0] raw_cnt;
    logic [CNT_W-1:0] clamped_cnt;

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start && !queue_full;

    always_comb
    begin
        prefill_next = prefill_reg;
        decode_next  = decode_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PREFILL: prefill_next = cfg_data;
                CFG_DECODE:  decode_next  = cfg_data;
                default:     prefill_next = prefill_reg;
            endcase
        end
    end

    always_comb
    begin
        raw_cnt = table_select ? decode_reg : prefill_reg;
        priority if (raw_cnt == '0)
        begin
            clamped_cnt = CNT_W'(1);
        end
        else if (32'(raw_cnt) > TABLE_DEPTH)
        begin
            clamped_cnt = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            clamped_cnt = raw_cnt;
        end
    end

    always_comb
    begin
        push_item.is_query = (func == FUNC_QUERY);
        push_item.sel      = table_select;
        push_item.wr_ok    = (32'(entry_index) < TABLE_DEPTH);
        push_item.idx      = entry_index;
        push_item.key      = entry_key;
        push_item.tval     = entry_time;
        push_item.count    = query_count;
        push_item.entries  = clamped_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefill_reg <= CNT_W'(1);
            decode_reg  <= CNT_W'(1);
        end
        else
        begin
            prefill_reg <= prefill_next;
            decode_reg  <= decode_next;
        end
    end

endmodule

[rtl/core/bsl_back.sv]
// Back part: table writes, binary search, interpolation and saturation.
module bsl_back
    import bsl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             head,
    input  logic              empty,
    output logic              pop,
    output logic              done,
    output logic [TIME_W-1:0] time_out,
    output logic [1:0]        status
);

    localparam int AW        = $clog2(2 * TABLE_DEPTH);
    localparam int PROD_W    = TIME_W + KEY_W;
    localparam int HALF_W    = TIME_W / 2;
    localparam int DIV_STEPS = PROD_W;
    localparam int DC_W      = $clog2(DIV_STEPS);
    localparam int V_W       = PROD_W + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_SWAIT = 4'd3;
    localparam logic [3:0] S_F1    = 4'd4;
    localparam logic [3:0] S_F2    = 4'd5;
    localparam logic [3:0] S_F3    = 4'd6;
    localparam logic [3:0] S_MUL0  = 4'd7;
    localparam logic [3:0] S_MUL1  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]              state_reg, state_next;
    logic                    sel_reg, sel_next;
    logic [KEY_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic [KEY_W-1:0]        k1_reg, k1_next;
    logic [TIME_W-1:0]       t1_reg, t1_next;
    logic [KEY_W-1:0]        k2_reg, k2_next;
    logic [TIME_W-1:0]       t2_reg, t2_next;
    logic                    neg_reg, neg_next;
    logic [TIME_W-1:0]       ud_reg, ud_next;
    logic [KEY_W-1:0]        uf_reg, uf_next;
    logic [KEY_W-1:0]        uden_reg, uden_next;
    logic [1:0]              stat_reg, stat_next;
    logic [HALF_W+KEY_W-1:0] plo_reg, plo_next;
    logic [PROD_W-1:0]       pq_reg, pq_next;
    logic [KEY_W-1:0]        rem_reg, rem_next;
    logic [DC_W-1:0]         dcnt_reg, dcnt_next;
    logic                    done_reg, done_next;
    logic [TIME_W-1:0]       tout_reg, tout_next;
    logic [1:0]              status_reg, status_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [KEY_W-1:0]        key_rdata;
    logic [TIME_W-1:0]       time_rdata;
    logic [AW-1:0]           base;
    logic [CNT_W:0]          mid_sum;
    logic signed [TIME_W:0]  d_s;
    logic signed [KEY_W:0]   f_s;
    logic signed [KEY_W:0]   den_s;
    logic [HALF_W+KEY_W-1:0] phi;
    logic [KEY_W:0]          rem_sh;
    logic [KEY_W:0]          rem_sub;
    logic                    ge;
    logic signed [V_W-1:0]   v_s;

    bsl_ram #(.WIDTH(KEY_W), .DEPTH(2 * TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.key),
        .rdata (key_rdata)
    );

    bsl_ram #(.WIDTH(TIME_W), .DEPTH(2 * TABLE_DEPTH)) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.tval),
        .rdata (time_rdata)
    );

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign done     = done_reg;
    assign time_out = tout_reg;
    assign status   = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        k1_next     = k1_reg;
        t1_next     = t1_reg;
        k2_next     = k2_reg;
        t2_next     = t2_reg;
        neg_next    = neg_reg;
        ud_next     = ud_reg;
        uf_next     = uf_reg;
        uden_next   = uden_reg;
        stat_next   = stat_reg;
        plo_next    = plo_reg;
        pq_next     = pq_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        done_next   = 1'b0;
        tout_next   = tout_reg;
        status_next = status_reg;
        ram_we      = 1'b0;

        base     = sel_reg ? AW'(TABLE_DEPTH) : '0;
        ram_addr = base;
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        d_s      = $signed({1'b0, t2_reg}) - $signed({1'b0, t1_reg});
        f_s      = $signed({1'b0, n_reg}) - $signed({1'b0, k1_reg});
        den_s    = $signed({1'b0, k2_reg}) - $signed({1'b0, k1_reg});
        phi      = ud_reg[TIME_W-1:HALF_W] * uf_reg;
        rem_sh   = {rem_reg, pq_reg[PROD_W-1]};
        rem_sub  = rem_sh - {1'b0, uden_reg};
        ge       = (rem_sh >= {1'b0, uden_reg});
        if (neg_reg)
        begin
            v_s = $signed({{(V_W-TIME_W){1'b0}}, t1_reg}) - $signed({2'b00, pq_reg})
                - $signed(V_W'(rem_reg != '0));
        end
        else
        begin
            v_s = $signed({{(V_W-TIME_W){1'b0}}, t1_reg}) + $signed({2'b00, pq_reg});
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    if (head.is_query)
                    begin
                        sel_next   = head.sel;
                        n_next     = head.count;
                        cnt_next   = head.entries;
                        ram_addr   = head.sel ? AW'(TABLE_DEPTH) : '0;
                        state_next = S_RD0;
                    end
                    else
                    begin
                        ram_we   = head.wr_ok;
                        ram_addr = (head.sel ? AW'(TABLE_DEPTH) : '0) + AW'(head.idx);
                    end
                end
            end
            S_RD0:
            begin
                if (n_reg <= key_rdata)
                begin
                    done_next   = 1'b1;
                    tout_next   = time_rdata;
                    status_next = ST_BELOW;
                    state_next  = S_IDLE;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    done_next   = 1'b1;
                    tout_next   = time_rdata;
                    status_next = ST_EXTRAP;
                    state_next  = S_IDLE;
                end
                else
                begin
                    lo_next    = CNT_W'(1);
                    hi_next    = cnt_reg - CNT_W'(1);
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[CNT_W:1];
                    ram_addr   = base + AW'(mid_sum[CNT_W:1]);
                    state_next = S_SWAIT;
                end
                else
                begin
                    ram_addr   = base + AW'(lo_reg - CNT_W'(1));
                    state_next = S_F1;
                end
            end
            S_SWAIT:
            begin
                if (n_reg > key_rdata)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_F1:
            begin
                k1_next    = key_rdata;
                t1_next    = time_rdata;
                ram_addr   = base + AW'(lo_reg);
                state_next = S_F2;
            end
            S_F2:
            begin
                k2_next    = key_rdata;
                t2_next    = time_rdata;
                state_next = S_F3;
            end
            S_F3:
            begin
                stat_next = (n_reg > k2_reg) ? ST_EXTRAP : ST_INTERP;
                ud_next   = d_s[TIME_W] ? TIME_W'(-d_s) : TIME_W'(d_s);
                uf_next   = f_s[KEY_W] ? KEY_W'(-f_s) : KEY_W'(f_s);
                uden_next = den_s[KEY_W] ? KEY_W'(-den_s) : KEY_W'(den_s);
                neg_next  = d_s[TIME_W] ^ f_s[KEY_W] ^ den_s[KEY_W];
                if (den_s == '0)
                begin
                    done_next   = 1'b1;
                    tout_next   = t1_reg;
                    status_next = (n_reg > k2_reg) ? ST_EXTRAP : ST_INTERP;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                plo_next   = ud_reg[HALF_W-1:0] * uf_reg;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                pq_next    = {phi, {HALF_W{1'b0}}} + PROD_W'(plo_reg);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? rem_sub[KEY_W-1:0] : rem_sh[KEY_W-1:0];
                pq_next   = {pq_reg[PROD_W-2:0], ge};
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                priority if (v_s < 0)
                begin
                    tout_next   = '0;
                    status_next = ST_SAT;
                end
                else if (v_s > $signed({{(V_W-TIME_W){1'b0}}, TIME_MAX}))
                begin
                    tout_next   = TIME_MAX;
                    status_next = ST_SAT;
                end
                else
                begin
                    tout_next   = v_s[TIME_W-1:0];
                    status_next = stat_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        n_reg      <= n_next;
        cnt_reg    <= cnt_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        k1_reg     <= k1_next;
        t1_reg     <= t1_next;
        k2_reg     <= k2_next;
        t2_reg     <= t2_next;
        neg_reg    <= neg_next;
        ud_reg     <= ud_next;
        uf_reg     <= uf_next;
        uden_reg   <= uden_next;
        stat_reg   <= stat_next;
        plo_reg    <= plo_next;
        pq_reg     <= pq_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        tout_reg   <= tout_next;
        status_reg <= status_next;
    end

endmodule

[rtl/core/breakpoint_search_lerp.sv]
// Top level of the breakpoint search and linear interpolation block.
// A write beat is stored when the back unit takes it from the queue and gives no result.
// A query at or below the first key, or on a one-entry table, is answered from the first entry alone.
// Other queries run the binary search, fetch both bracketing entries, multiply and then divide
// in the 68-step divider before done; equal bracketing keys skip the multiply and divider.
// The back unit works on one beat at a time; busy is high only while the two-beat queue is full.
// Reset clears control state and sets both entry counts to 1; table contents stay undefined.
module breakpoint_search_lerp
    import bsl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  logic              table_select,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [KEY_W-1:0]  entry_key,
    input  logic [TIME_W-1:0] entry_time,
    input  logic [KEY_W-1:0]  query_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,
    output logic              done,
    output logic [TIME_W-1:0] time_out,
    output logic [1:0]        status
);

    logic  push;
    item_t push_item;
    logic  pop;
    item_t head;
    logic  empty;
    logic  full;

    bsl_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .table_select (table_select),
        .entry_index  (entry_index),
        .entry_key    (entry_key),
        .entry_time   (entry_time),
        .query_count  (query_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (full),
        .push         (push),
        .push_item    (push_item)
    );

    bsl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    bsl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .done     (done),
        .time_out (time_out),
        .status   (status)
    );

endmodule

[rtl/core/bsl_checker.sv]
// Port-level checks of the breakpoint search and interpolation block.
module bsl_checker
    import bsl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              done,
    input logic [TIME_W-1:0] time_out,
    input logic [1:0]        status
);

    // Every query spends at least a read and a compare, so results never come in adjacent cycles.
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Two results in adjacent cycles.");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("Configuration channel stalled.");

    a_sat_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_SAT) |-> (time_out == '0 || time_out == TIME_MAX))
        else $error("Saturated result is not at a range limit.");

    // Right after reset the queue is empty and no result is pending.
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (!done && !busy))
        else $error("Block not idle right after reset.");

endmodule

bind breakpoint_search_lerp bsl_checker u_bsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .done      (done),
    .time_out  (time_out),
    .status    (status)
);

[dv/breakpoint_search_lerp_test.sv]
// Self-checking testbench for the breakpoint search and interpolation block.
module breakpoint_search_lerp_test;
    import bsl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 256;
    localparam int STALL_MAX  = 5000;
    localparam int ITEM_GOAL  = 550;

    class lerp_scoreboard;
        logic [KEY_W-1:0]  key_tbl[2*DEPTH];
        logic [TIME_W-1:0] time_tbl[2*DEPTH];
        logic [CNT_W-1:0]  entries[2];
        logic [TIME_W-1:0] time_q[$];
        logic [1:0]        status_q[$];
        int                mismatches;

        function new();
            entries[0] = 1;
            entries[1] = 1;
            mismatches = 0;
        endfunction

        function int pending();
            return time_q.size();
        endfunction

        function void set_entries(logic sel, logic [CNT_W-1:0] value);
            entries[sel] = value;
        endfunction

        function void lerp_time(logic sel, logic [KEY_W-1:0] count,
                                output logic [TIME_W-1:0] t, output logic [1:0] st);
            longint n, k1, k2, t1, t2, d, f, den, v;
            longint unsigned ud, uf, uden, a, r, p, qm, big;
            bit neg, huge, frac;
            int base, cnt, lo, hi, mid;
            big = 64'd1 << 50;
            base = sel * DEPTH;
            cnt = entries[sel];
            if (cnt == 0) cnt = 1;
            if (cnt > DEPTH) cnt = DEPTH;
            n = count;
            if (n <= longint'(key_tbl[base])) begin
                t = time_tbl[base];
                st = ST_BELOW;
                return;
            end
            if (cnt == 1) begin
                t = time_tbl[base];
                st = ST_EXTRAP;
                return;
            end
            lo = 1;
            hi = cnt - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (n > longint'(key_tbl[base+mid])) lo = mid + 1;
                else hi = mid;
            end
            k1 = key_tbl[base+lo-1];
            k2 = key_tbl[base+lo];
            t1 = time_tbl[base+lo-1];
            t2 = time_tbl[base+lo];
            d = t2 - t1;
            f = n - k1;
            den = k2 - k1;
            st = (n > k2) ? ST_EXTRAP : ST_INTERP;
            if (den == 0) begin
                t = t1[TIME_W-1:0];
                return;
            end
            neg = ((d < 0) != (f < 0)) != (den < 0);
            ud = (d < 0) ? -d : d;
            uf = (f < 0) ? -f : f;
            uden = (den < 0) ? -den : den;
            a = ud / uden;
            r = ud % uden;
            huge = (uf != 0 && a != 0 && a > big / uf);
            v = 0;
            if (!huge) begin
                p = r * uf;
                qm = a * uf + p / uden;
                frac = (p % uden) != 0;
                if (qm >= big) huge = 1;
                else if (neg) v = t1 - longint'(qm) - (frac ? 1 : 0);
                else v = t1 + longint'(qm);
            end
            if (huge) begin
                t = neg ? '0 : TIME_MAX;
                st = ST_SAT;
            end else if (v < 0) begin
                t = '0;
                st = ST_SAT;
            end else if (v > longint'(TIME_MAX)) begin
                t = TIME_MAX;
                st = ST_SAT;
            end else begin
                t = v[TIME_W-1:0];
            end
        endfunction

        function void note_beat(logic fn, logic sel, logic [IDX_W-1:0] idx,
                                logic [KEY_W-1:0] key, logic [TIME_W-1:0] tm,
                                logic [KEY_W-1:0] count);
            logic [TIME_W-1:0] t;
            logic [1:0] st;
            if (fn == FUNC_WRITE) begin
                key_tbl[sel*DEPTH+idx] = key;
                time_tbl[sel*DEPTH+idx] = tm;
            end else begin
                lerp_time(sel, count, t, st);
                time_q.push_back(t);
                status_q.push_back(st);
            end
        endfunction

        function void check_beat(logic [TIME_W-1:0] t, logic [1:0] st);
            logic [TIME_W-1:0] et;
            logic [1:0] es;
            if (time_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: time %0d status %0d", t, st);
                return;
            end
            et = time_q.pop_front();
            es = status_q.pop_front();
            if (t !== et || st !== es) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: time exp %0d got %0d, status exp %0d got %0d",
                             et, t, es, st);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              func;
    logic              table_select;
    logic [IDX_W-1:0]  entry_index;
    logic [KEY_W-1:0]  entry_key;
    logic [TIME_W-1:0] entry_time;
    logic [KEY_W-1:0]  query_count;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [CNT_W-1:0]  cfg_data;
    logic              done;
    logic [TIME_W-1:0] time_out;
    logic [1:0]        status;

    lerp_scoreboard sb = new();
    bit no_idle = 0;
    int stall_cycles = 0;
    int sent_items = 0;
    logic [KEY_W-1:0] top_key[2];

    breakpoint_search_lerp #(.TABLE_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .table_select(table_select), .entry_index(entry_index), .entry_key(entry_key),
        .entry_time(entry_time), .query_count(query_count), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .time_out(time_out), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_beat(time_out, status);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(logic fn, logic sel, logic [IDX_W-1:0] idx,
                             logic [KEY_W-1:0] key, logic [TIME_W-1:0] tm,
                             logic [KEY_W-1:0] count);
        if (!no_idle && $urandom_range(99) < 19) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        func <= fn;
        table_select <= sel;
        entry_index <= idx;
        entry_key <= key;
        entry_time <= tm;
        query_count <= count;
        do @(posedge clk); while (busy);
        sb.note_beat(fn, sel, idx, key, tm, count);
        sent_items++;
    endtask

    task automatic query(logic sel, logic [KEY_W-1:0] count);
        send_beat(FUNC_QUERY, sel, IDX_W'($urandom), KEY_W'($urandom),
                  TIME_W'({$urandom, $urandom}), count);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_entries(idx, value);
    endtask

    function automatic int used_entries(logic [CNT_W-1:0] value);
        if (value == 0) return 1;
        if (value > DEPTH) return DEPTH;
        return value;
    endfunction

    // Modes: 0 ascending, 1 ascending with repeated keys, 2 unsorted, 3 steep swings.
    task automatic load_table(logic sel, int count, int mode);
        logic [KEY_W-1:0] key;
        logic [TIME_W-1:0] tm;
        longint kacc, tacc;
        int step;
        kacc = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4000);
        tacc = $urandom_range(0, 1 << 20);
        step = (count > 0) ? (1048000 / count) : 1;
        for (int i = 0; i < count; i++) begin
            case (mode)
                0, 1:
                begin
                    if (!(mode == 1 && $urandom_range(1) == 1) || i == 0)
                        kacc += $urandom_range(1, step);
                    if (kacc > 1048575) kacc = 1048575;
                    tacc += {$urandom_range(0, 255), $urandom};
                    if (tacc > longint'(TIME_MAX)) tacc = longint'(TIME_MAX);
                    key = KEY_W'(kacc);
                    tm = TIME_W'(tacc);
                end
                2:
                begin
                    key = KEY_W'($urandom);
                    tm = TIME_W'({$urandom, $urandom});
                end
                default:
                begin
                    kacc += $urandom_range(1, 3);
                    key = KEY_W'(kacc);
                    tm = (i % 2 == 0) ? TIME_W'($urandom_range(0, 1000))
                                      : TIME_MAX - TIME_W'($urandom_range(0, 1000));
                end
            endcase
            if (i == count - 1) top_key[sel] = key;
            send_beat(FUNC_WRITE, sel, IDX_W'(i), key, tm, KEY_W'($urandom));
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_count(logic sel);
        int margin;
        margin = $urandom_range(0, 3);
        if (margin == 0) return KEY_W'($urandom);
        if (margin == 1) return KEY_W'(top_key[sel] + $urandom_range(0, 5000));
        return KEY_W'($urandom_range(0, top_key[sel]));
    endfunction

    initial
    begin
        logic [CNT_W-1:0] cfg_set[2];
        logic sel;
        int phase;
        rst_n <= 1'b0;
        start <= 1'b0;
        func <= FUNC_WRITE;
        table_select <= CFG_PREFILL;
        entry_index <= '0;
        entry_key <= '0;
        entry_time <= '0;
        query_count <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PREFILL;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_table(CFG_PREFILL, DEPTH, 0);
        load_table(CFG_DECODE, 32, 2);
        query(CFG_PREFILL, 20'd0);
        query(CFG_PREFILL, 20'hFFFFF);
        query(CFG_DECODE, 20'hFFFFF);
        drain();

        write_cfg(CFG_PREFILL, 9'd511);
        write_cfg(CFG_DECODE, 9'd32);
        query(CFG_PREFILL, 20'd0);
        query(CFG_PREFILL, sb.key_tbl[0]);
        query(CFG_PREFILL, sb.key_tbl[1]);
        query(CFG_PREFILL, KEY_W'(sb.key_tbl[100] + 1));
        query(CFG_PREFILL, sb.key_tbl[255]);
        query(CFG_PREFILL, 20'hFFFFF);
        query(CFG_DECODE, 20'hFFFFF);
        query(CFG_DECODE, 20'h55555);
        query(CFG_DECODE, 20'hAAAAA);
        drain();

        write_cfg(CFG_PREFILL, 9'd0);
        write_cfg(CFG_DECODE, 9'd2);
        load_table(CFG_DECODE, 2, 3);
        query(CFG_PREFILL, 20'hFFFFF);
        query(CFG_PREFILL, 20'd0);
        query(CFG_DECODE, top_key[CFG_DECODE] + 20'd4000);
        query(CFG_DECODE, top_key[CFG_DECODE] + 20'd1);
        load_table(CFG_DECODE, 2, 1);
        query(CFG_DECODE, top_key[CFG_DECODE]);
        query(CFG_DECODE, top_key[CFG_DECODE] + 20'd9);
        drain();

        phase = 0;
        while (sent_items < ITEM_GOAL) begin
            case (phase % 6)
                0: begin cfg_set[0] = 9'd1;   cfg_set[1] = 9'd20; end
                1: begin cfg_set[0] = 9'd20;  cfg_set[1] = 9'd0;  end
                2: begin cfg_set[0] = 9'd2;   cfg_set[1] = 9'd3;  end
                default:
                begin
                    cfg_set[0] = CNT_W'($urandom_range(1, 24));
                    cfg_set[1] = $urandom_range(0, 4) == 0 ? CNT_W'(0)
                                                           : CNT_W'($urandom_range(1, 24));
                end
            endcase
            no_idle = (phase == 4);
            write_cfg(CFG_PREFILL, cfg_set[0]);
            write_cfg(CFG_DECODE, cfg_set[1]);
            for (int s = 0; s < 2; s++)
                load_table(s[0], used_entries(cfg_set[s]), $urandom_range(0, 3));
            for (int k = 0; k < 30; k++) begin
                sel = $urandom_range(1);
                if ($urandom_range(99) < 75) begin
                    query(sel, pick_count(sel));
                end else begin
                    send_beat(FUNC_WRITE, sel,
                              IDX_W'($urandom_range(0, used_entries(cfg_set[sel]) - 1)),
                              KEY_W'($urandom), TIME_W'({$urandom, $urandom}),
                              KEY_W'($urandom));
                end
            end
            drain();
            phase++;
        end
        no_idle = 0;

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
